@@ rtl/lir_pkg.sv @@
// shared constants and types of the linear interpolation resampler
// no dependencies
package lir_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int STEP_BITS   = 20;
  localparam int PHASE_BITS  = 20;
  localparam int MAX_OUT     = 8;
  localparam int CNT_BITS    = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_BITS   = 2 * (SAMPLE_BITS + 1);

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = STEP_BITS'(76364);
  localparam logic [PHASE_BITS-1:0] PHASE_ONE   = PHASE_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0]  STEP_MIN    = (STEP_BITS'(1) << FRAC_BITS) >> 3;
  localparam logic [STEP_BITS-1:0]  STEP_MAX    = STEP_BITS'(1) << (FRAC_BITS + 3);
  localparam logic [PHASE_BITS-1:0] PHASE_RESET =
    PHASE_BITS'(STEP_RESET) + (PHASE_ONE << 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t prev_l;
    sample_t prev_r;
    sample_t cur_l;
    sample_t cur_r;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/lir_front.sv @@
// front end: takes source words and forms previous/current sample pairs
// depends on lir_pkg
module lir_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lir_pkg::sample_t in_left,
  input  lir_pkg::sample_t in_right,
  input  lir_pkg::q_stat_t q_stat,
  output logic             q_push,
  output lir_pkg::pair_t   q_wdata
);
  import lir_pkg::*;

  sample_t cur_l_r;
  sample_t cur_r_r;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata.prev_l = cur_l_r;
    q_wdata.prev_r = cur_r_r;
    q_wdata.cur_l  = in_left;
    q_wdata.cur_r  = in_right;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_l_r <= '0;
      cur_r_r <= '0;
    end else if (q_push) begin
      cur_l_r <= in_left;
      cur_r_r <= in_right;
    end
  end

endmodule

@@ rtl/lir_queue.sv @@
// short queue of sample pairs between front and back end
// depends on lir_pkg
module lir_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lir_pkg::pair_t   wdata,
  input  logic             pop,
  output lir_pkg::pair_t   rdata,
  output lir_pkg::q_stat_t stat
);
  import lir_pkg::*;

  pair_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end
  end

endmodule

@@ rtl/lir_back.sv @@
// back end: phase accumulator, interpolation multipliers and output register
// depends on lir_pkg
module lir_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lir_pkg::STEP_BITS-1:0] step,
  input  lir_pkg::q_stat_t              q_stat,
  input  lir_pkg::pair_t                q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lir_pkg::sample_t              out_left,
  output lir_pkg::sample_t              out_right,
  output logic                          out_last
);
  import lir_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_r;
  logic                    state_nxt;
  pair_t                   pair_r;
  logic [PHASE_BITS-1:0]   phase_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic [STEP_BITS-1:0]    step_eff;
  logic [PHASE_BITS:0]     phase_sum;
  logic                    can_issue;
  logic                    issue;
  logic                    issue_last;
  logic                    adv;
  logic [FRAC_BITS:0]      frac;
  logic signed [SAMPLE_BITS:0] diff_l;
  logic signed [SAMPLE_BITS:0] diff_r;

  logic                        s1_valid_r;
  logic                        s1_last_r;
  sample_t                     s1_base_l_r;
  sample_t                     s1_base_r_r;
  logic signed [PROD_BITS-1:0] s1_prod_l_r;
  logic signed [PROD_BITS-1:0] s1_prod_r_r;
  logic signed [PROD_BITS-1:0] sh_l;
  logic signed [PROD_BITS-1:0] sh_r;

  logic    out_valid_r;
  logic    out_last_r;
  sample_t out_left_r;
  sample_t out_right_r;

  always_comb begin
    priority if (step < STEP_MIN) begin
      step_eff = STEP_MIN;
    end else if (step > STEP_MAX) begin
      step_eff = STEP_MAX;
    end else begin
      step_eff = step;
    end
  end

  assign adv        = !out_valid_r || out_ready;
  assign phase_sum  = {1'b0, phase_r} + (PHASE_BITS + 1)'(step_eff);
  assign can_issue  = (phase_r < PHASE_ONE) && (cnt_r < CNT_BITS'(MAX_OUT));
  assign issue      = (state_r == ST_RUN) && can_issue && adv;
  assign issue_last = (phase_sum >= (PHASE_BITS + 1)'(PHASE_ONE))
                      || (cnt_r == CNT_BITS'(MAX_OUT - 1));
  assign q_pop      = (state_r == ST_IDLE) && !q_stat.empty;

  assign frac   = {1'b0, phase_r[FRAC_BITS-1:0]};
  assign diff_l = (SAMPLE_BITS + 1)'(pair_r.cur_l) - (SAMPLE_BITS + 1)'(pair_r.prev_l);
  assign diff_r = (SAMPLE_BITS + 1)'(pair_r.cur_r) - (SAMPLE_BITS + 1)'(pair_r.prev_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!can_issue || (issue && issue_last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PHASE_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        phase_r <= (phase_r >= PHASE_ONE) ? phase_r - PHASE_ONE : '0;
        cnt_r   <= '0;
      end else if (issue) begin
        phase_r <= phase_sum[PHASE_BITS-1:0];
        cnt_r   <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pair_r <= q_rdata;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r   <= issue_last;
      s1_base_l_r <= pair_r.prev_l;
      s1_base_r_r <= pair_r.prev_r;
      s1_prod_l_r <= diff_l * $signed(frac);
      s1_prod_r_r <= diff_r * $signed(frac);
    end
  end

  // floor by arithmetic shift, then add to previous sample
  assign sh_l = s1_prod_l_r >>> FRAC_BITS;
  assign sh_r = s1_prod_r_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r  <= s1_last_r;
      out_left_r  <= s1_base_l_r + sh_l[SAMPLE_BITS-1:0];
      out_right_r <= s1_base_r_r + sh_r[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

@@ rtl/linear_interp_resampler.sv @@
// top level of the stereo linear interpolation resampler
// depends on lir_pkg, lir_front, lir_queue, lir_back
//
// in channel: one stereo source word per handshake (left in the low half).
// out channel: interpolated stereo words; tlast marks the final word that a
//   source word produces. a source word may produce no output word at all.
// cfg channel: step ratio, unsigned with 16 fraction bits, always ready;
//   values outside 0.125 to 8.0 are clamped. write only while idle.
// path: a source word passes the pair queue, the pair register, the multiply
//   stage and the output register; the phase sequencer takes a new pair only
//   in its idle state, after issuing every output word of the last one; one
//   multiplier pass per output word, at most 8 outputs per source word.
// the front end keeps taking words while the two-entry pair queue has room.
// reset: samples clear to zero, step ratio to about 1.165 and the phase to
//   step plus two, so the first output comes from the third source word.
// when the receiver stalls, the output register holds, the multiply stage
//   freezes and the sequencer stops issuing output words; the queue then
//   fills and in_tready drops.
module linear_interp_resampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // left_sample, right_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // left_out, right_out
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  import lir_pkg::*;

  logic [STEP_BITS-1:0] step_r;
  q_stat_t              q_stat;
  logic                 q_push;
  logic                 q_pop;
  pair_t                q_wdata;
  pair_t                q_rdata;
  sample_t              out_left;
  sample_t              out_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_data;
    end
  end

  lir_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_left  (in_tdata[15:0]),
    .in_right (in_tdata[31:16]),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  lir_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  lir_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_r),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_right, out_left};

endmodule

@@ rtl/lir_checker.sv @@
// port-level checks for the resampler, attached by bind
// depends on linear_interp_resampler
module lir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid && in_tready)
    else $error("bad state right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);

@@ tb/tb.sv @@
// testbench of linear_interp_resampler: drives stereo source words, checks the
// interpolated output words against a behavioral predictor of the resampler
// depends on lir_pkg and the rtl of linear_interp_resampler
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_SETTING = 27;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    silent;
    logic    typed;
  } row_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } out_word_t;

  // silent: no output after reset; typed: repeated sample, outputs equal it
  localparam row_t DIR_ROWS [14] = '{
    '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0},
    '{16'sh7FFF, 16'sh8000, 1'b0, 1'b1},
    '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0},
    '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0},
    '{16'shFFFF, 16'shFFFF, 1'b0, 1'b0},
    '{16'sh0001, 16'shFFFF, 1'b0, 1'b0},
    '{16'sh5555, 16'shAAAA, 1'b0, 1'b0},
    '{16'shAAAA, 16'sh5555, 1'b0, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b1},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1},
    '{16'sh1234, 16'shEDCB, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // left_sample, right_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // left_out, right_out
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data = '0;

  logic [STEP_BITS-1:0]  step_reg;
  logic [PHASE_BITS-1:0] phase_acc;
  sample_t               prev_l, prev_r, cur_l, cur_r;
  out_word_t             pending_words[$];
  int                    mismatches = 0;
  int                    cycles = 0;
  int                    stall_left = 0;
  bit                    no_gaps = 1'b0;

  linear_interp_resampler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // a + floor((b - a) * frac / 2^FRAC_BITS)
  function automatic sample_t lerp_floor(sample_t a, sample_t b, logic [FRAC_BITS-1:0] frac);
    longint d, p;
    d = longint'(b) - longint'(a);
    p = d * longint'(frac);
    return sample_t'(longint'(a) + (p >>> FRAC_BITS));
  endfunction

  task automatic interp_step(sample_t l, sample_t r, bit silent, bit typed);
    logic [STEP_BITS-1:0] eff;
    out_word_t w;
    int n;
    eff = step_reg;
    if (eff < STEP_MIN) eff = STEP_MIN;
    if (eff > STEP_MAX) eff = STEP_MAX;
    prev_l = cur_l;
    prev_r = cur_r;
    cur_l = l;
    cur_r = r;
    if (phase_acc >= PHASE_ONE) phase_acc = phase_acc - PHASE_ONE;
    else phase_acc = '0;
    n = 0;
    while (phase_acc < PHASE_ONE && n < MAX_OUT) begin
      w.left  = typed ? l : lerp_floor(prev_l, cur_l, phase_acc[FRAC_BITS-1:0]);
      w.right = typed ? r : lerp_floor(prev_r, cur_r, phase_acc[FRAC_BITS-1:0]);
      phase_acc = phase_acc + PHASE_BITS'(eff);
      n++;
      w.last = !(phase_acc < PHASE_ONE && n < MAX_OUT);
      if (!silent) pending_words.push_back(w);
    end
  endtask

  task automatic send_word(sample_t l, sample_t r, bit silent, bit typed);
    int g;
    @(negedge clk);
    in_tdata = {r, l};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    interp_step(l, r, silent, typed);
    g = no_gaps ? 0 : idle_len();
    if (g > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // drain, let any word without output leave the pipeline, then write
  task automatic write_step(logic [STEP_BITS-1:0] v);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    step_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (no_gaps) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= idle_len();
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word left %0d right %0d last %0b", $time,
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tlast);
      end else begin
        w = pending_words.pop_front();
        if (out_tdata[15:0] !== w.left) begin
          mismatches++;
          $display("%0t: left_out expected %0d actual %0d", $time, w.left,
                   $signed(out_tdata[15:0]));
        end
        if (out_tdata[31:16] !== w.right) begin
          mismatches++;
          $display("%0t: right_out expected %0d actual %0d", $time, w.right,
                   $signed(out_tdata[31:16]));
        end
        if (out_tlast !== w.last) begin
          mismatches++;
          $display("%0t: last_in_run expected %0b actual %0b", $time, w.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[linear_interp_resampler] ERROR");
      $finish;
    end
  end

  initial begin
    logic [STEP_BITS-1:0] settings [10];
    step_reg = STEP_RESET;
    phase_acc = PHASE_RESET;
    prev_l = '0;
    prev_r = '0;
    cur_l = '0;
    cur_r = '0;
    settings = '{20'd8192, 20'd524288, 20'd0, 20'hFFFFF, 20'd65536,
                 20'd4095, 20'd600000, 20'd131072, 20'd0, 20'd0};
    settings[8] = STEP_BITS'($urandom_range(8192, 524288));
    settings[9] = STEP_BITS'($urandom_range(0, 1048575));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i])
      send_word(DIR_ROWS[i].left, DIR_ROWS[i].right, DIR_ROWS[i].silent, DIR_ROWS[i].typed);

    foreach (settings[s]) begin
      write_step(settings[s]);
      no_gaps = (s % 3 == 1);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_word(cur_l, cur_r, 1'b0, 1'b0);
        else
          send_word(pick_sample(), pick_sample(), 1'b0, 1'b0);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    no_gaps = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[linear_interp_resampler] OK");
    else
      $display("[linear_interp_resampler] ERROR");
    $finish;
  end

endmodule

@@ linear_interp_resampler.f @@
rtl/lir_pkg.sv
rtl/lir_front.sv
rtl/lir_queue.sv
rtl/lir_back.sv
rtl/linear_interp_resampler.sv
rtl/lir_checker.sv
tb/tb.sv
